// File: hw/rtl/rpq_pkg.sv
`timescale 1ns / 1ps

package rpq_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_QUERY   = 3'd0,
    CMD_ENQUEUE = 3'd1,
    CMD_REMOVE  = 3'd2,
    CMD_REQUEUE = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  localparam logic [1:0] KIND_REGISTER  = 2'd0;
  localparam logic [1:0] KIND_HEARTBEAT = 2'd2;

  typedef struct packed {
    logic [15:0]          tag;
    logic [1:0]           kind;
    logic [2:0]           prio;
    logic [7:0]           retries;
    logic [31:0]          created;
    logic [TIME_BITS-1:0] retry_time;
  } task_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_e;

  // Broadcast to every cell of the chain in a cycle.
  typedef struct packed {
    cell_op_e op;
    task_t    new_task;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/retry_priority_task_queue.sv
`timescale 1ns / 1ps

// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    command_i, task_*_i, now_ms_i, backoff_ms_i
// out      out_valid_o / out_ready_i  status_o, head_*_o, task_count_o
//
// Query, enqueue, remove and clear go from transfer through S_REPORT to the output register;
// requeue pulls the head on transfer, reinserts it in S_INSERT and then goes through S_REPORT.
// Every cell of the chain moves in the same cycle on each pull, shift or insert.
// Reset empties the queue at once; the cell contents are left as they are.
// A new command is taken only once the previous one has reached the output register.
// A stalled result waits in that register; the next command then runs up to it.

module retry_priority_task_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    command_i,
  input  logic [1:0]                    task_kind_i,
  input  logic [15:0]                   task_tag_i,
  input  logic [2:0]                    task_priority_i,
  input  logic [7:0]                    task_retries_i,
  input  logic [31:0]                   task_created_i,
  input  logic [rpq_pkg::TIME_BITS-1:0] task_retry_time_i,
  input  logic [rpq_pkg::TIME_BITS-1:0] now_ms_i,
  input  logic [31:0]                   backoff_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic                          head_valid_o,
  output logic                          head_ready_o,
  output logic [15:0]                   head_tag_o,
  output logic [1:0]                    head_kind_o,
  output logic [2:0]                    head_priority_o,
  output logic [7:0]                    head_retries_o,
  output logic [31:0]                   head_created_o,
  output logic [rpq_pkg::TIME_BITS-1:0] head_retry_time_o,
  output logic [4:0]                    task_count_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_REPORT
  } state_e;

  state_e                          state_q;
  logic [rpq_pkg::CNT_W-1:0]       count_q;
  rpq_pkg::status_e                status_q;
  logic [rpq_pkg::TIME_BITS-1:0]   now_q;
  rpq_pkg::task_t                  pending_q;

  logic                            out_valid_q;
  rpq_pkg::status_e                out_status_q;
  logic                            out_head_valid_q;
  logic                            out_head_ready_q;
  rpq_pkg::task_t                  out_head_q;
  logic [4:0]                      out_count_q;

  rpq_pkg::cell_ctrl_t             ctrl;
  rpq_pkg::task_t                  in_task;
  rpq_pkg::task_t                  cell_task [rpq_pkg::DEPTH];
  logic [rpq_pkg::DEPTH-1:0]       occupied;
  logic [rpq_pkg::DEPTH-1:0]       after;
  logic [rpq_pkg::DEPTH-1:0]       kind_match;

  rpq_pkg::status_e                in_status;
  logic [rpq_pkg::CNT_W-1:0]       count_next;
  logic                            requeue_go;
  rpq_pkg::task_t                  requeue_task;

  logic in_fire;
  logic is_empty;
  logic is_full;
  logic dup;
  logic out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_empty   = (count_q == '0);
  assign is_full    = (count_q == rpq_pkg::CNT_W'(rpq_pkg::DEPTH));
  assign out_free   = !out_valid_q || out_ready_i;

  assign in_task.tag        = task_tag_i;
  assign in_task.kind       = task_kind_i;
  assign in_task.prio       = task_priority_i;
  assign in_task.retries    = task_retries_i;
  assign in_task.created    = task_created_i;
  assign in_task.retry_time = task_retry_time_i;

  // Only register and heartbeat tasks are unique per kind.
  assign dup = ((task_kind_i == rpq_pkg::KIND_REGISTER) ||
                (task_kind_i == rpq_pkg::KIND_HEARTBEAT)) && (|kind_match);

  always_comb begin
    in_status  = rpq_pkg::ST_DONE;
    count_next = count_q;
    case (rpq_pkg::cmd_e'(command_i))
      rpq_pkg::CMD_ENQUEUE: begin
        if (dup) begin
          in_status = rpq_pkg::ST_DUP;
        end else if (is_full) begin
          in_status = rpq_pkg::ST_FULL;
        end else begin
          count_next = count_q + 1'b1;
        end
      end
      rpq_pkg::CMD_REMOVE, rpq_pkg::CMD_REQUEUE: begin
        if (is_empty) begin
          in_status = rpq_pkg::ST_EMPTY;
        end else begin
          count_next = count_q - 1'b1;
        end
      end
      rpq_pkg::CMD_CLEAR: count_next = '0;
      default: ;
    endcase
  end

  assign requeue_go = (command_i == rpq_pkg::CMD_REQUEUE) && !is_empty;

  always_comb begin
    requeue_task            = cell_task[0];
    requeue_task.retries    = (cell_task[0].retries == 8'hFF) ?
                              8'hFF : cell_task[0].retries + 8'd1;
    requeue_task.retry_time = now_ms_i + rpq_pkg::TIME_BITS'(backoff_ms_i);
  end

  always_comb begin
    ctrl.op       = rpq_pkg::CELL_HOLD;
    ctrl.new_task = (state_q == S_INSERT) ? pending_q : in_task;
    if (state_q == S_INSERT) begin
      ctrl.op = rpq_pkg::CELL_INSERT;
    end else if (in_fire) begin
      case (rpq_pkg::cmd_e'(command_i))
        rpq_pkg::CMD_ENQUEUE: begin
          if (!dup && !is_full) begin
            ctrl.op = rpq_pkg::CELL_INSERT;
          end
        end
        rpq_pkg::CMD_REMOVE, rpq_pkg::CMD_REQUEUE: begin
          if (!is_empty) begin
            ctrl.op = rpq_pkg::CELL_SHIFT;
          end
        end
        default: ctrl.op = rpq_pkg::CELL_HOLD;
      endcase
    end
  end

  for (genvar i = 0; i < rpq_pkg::DEPTH; i++) begin : g_cell
    rpq_pkg::task_t left_task;
    rpq_pkg::task_t right_task;
    logic           left_after;

    assign occupied[i] = (rpq_pkg::CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_task  = cell_task[i];
      assign left_after = 1'b1;
    end else begin : g_mid
      assign left_task  = cell_task[i-1];
      assign left_after = after[i-1];
    end

    if (i == rpq_pkg::DEPTH - 1) begin : g_last
      assign right_task = cell_task[i];
    end else begin : g_inner
      assign right_task = cell_task[i+1];
    end

    rpq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (occupied[i]),
      .left_after_i (left_after),
      .left_task_i  (left_task),
      .right_task_i (right_task),
      .after_o      (after[i]),
      .kind_match_o (kind_match[i]),
      .task_o       (cell_task[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      count_q          <= '0;
      status_q         <= rpq_pkg::ST_DONE;
      now_q            <= '0;
      pending_q        <= '0;
      out_valid_q      <= 1'b0;
      out_status_q     <= rpq_pkg::ST_DONE;
      out_head_valid_q <= 1'b0;
      out_head_ready_q <= 1'b0;
      out_head_q       <= '0;
      out_count_q      <= '0;
    end else begin
      // In S_REPORT the output register is handled below.
      if (out_ready_i && (state_q != S_REPORT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            now_q    <= now_ms_i;
            status_q <= in_status;
            count_q  <= count_next;
            if (requeue_go) begin
              pending_q <= requeue_task;
              state_q   <= S_INSERT;
            end else begin
              state_q   <= S_REPORT;
            end
          end
        end
        S_INSERT: begin
          count_q <= count_q + 1'b1;
          state_q <= S_REPORT;
        end
        S_REPORT: begin
          if (out_free) begin
            out_valid_q      <= 1'b1;
            out_status_q     <= status_q;
            out_head_valid_q <= !is_empty;
            out_head_ready_q <= !is_empty && (now_q >= cell_task[0].retry_time);
            out_head_q       <= is_empty ? '0 : cell_task[0];
            out_count_q      <= 5'(count_q);
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign head_valid_o      = out_head_valid_q;
  assign head_ready_o      = out_head_ready_q;
  assign head_tag_o        = out_head_q.tag;
  assign head_kind_o       = out_head_q.kind;
  assign head_priority_o   = out_head_q.prio;
  assign head_retries_o    = out_head_q.retries;
  assign head_created_o    = out_head_q.created;
  assign head_retry_time_o = out_head_q.retry_time;
  assign task_count_o      = out_count_q;

endmodule

// File: hw/rtl/rpq_cell.sv
`timescale 1ns / 1ps

module rpq_cell (
  input  logic               clk_i,
  input  rpq_pkg::cell_ctrl_t ctrl_i,
  input  logic               occupied_i,
  input  logic               left_after_i,
  input  rpq_pkg::task_t     left_task_i,
  input  rpq_pkg::task_t     right_task_i,
  output logic               after_o,
  output logic               kind_match_o,
  output rpq_pkg::task_t     task_o
);

  rpq_pkg::task_t task_q, task_d;

  // The new task goes behind this entry when this entry's key is not larger.
  assign after_o = occupied_i &&
                   ((task_q.prio < ctrl_i.new_task.prio) ||
                    ((task_q.prio == ctrl_i.new_task.prio) &&
                     (task_q.retry_time <= ctrl_i.new_task.retry_time)));

  assign kind_match_o = occupied_i && (task_q.kind == ctrl_i.new_task.kind);

  always_comb begin
    task_d = task_q;
    case (ctrl_i.op)
      rpq_pkg::CELL_INSERT: begin
        if (!after_o) begin
          task_d = left_after_i ? ctrl_i.new_task : left_task_i;
        end
      end
      rpq_pkg::CELL_SHIFT: task_d = right_task_i;
      default: task_d = task_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    task_q <= task_d;
  end

  assign task_o = task_q;

endmodule
